FILE: hdl/key_and_tilt_supervisor_top_macros.svh
// Assertion macros shared by the key and tilt supervisor RTL.
// No dependencies; expects i_clk and i_rst_n in the including module.
`ifndef KEY_AND_TILT_SUPERVISOR_TOP_MACROS_SVH
`define KEY_AND_TILT_SUPERVISOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define KTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ktsup assertion failed");

// next-cycle implication, checked out of reset
`define KTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ktsup assertion failed");

`endif

FILE: hdl/ktsup_pkg.sv
// Package for the key and tilt supervisor: config struct, result struct,
// register indexes and reset values. No dependencies.
package ktsup_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [2:0] {
        REG_DEBOUNCE_TICKS     = 3'd0,
        REG_MAX_SETTING        = 3'd1,
        REG_TILT_CONFIRM_TICKS = 3'd2,
        REG_TILT_RECOVER_TICKS = 3'd3,
        REG_TICKS_PER_SECOND   = 3'd4,
        REG_FAN_HOLD_SECONDS   = 3'd5
    } t_reg_idx;

    localparam logic [7:0] RST_DEBOUNCE_TICKS     = 8'd5;
    localparam logic [3:0] RST_MAX_SETTING        = 4'd15;
    localparam logic [9:0] RST_TILT_CONFIRM_TICKS = 10'd100;
    localparam logic [9:0] RST_TILT_RECOVER_TICKS = 10'd200;
    localparam logic [9:0] RST_TICKS_PER_SECOND   = 10'd100;
    localparam logic [7:0] RST_FAN_HOLD_SECONDS   = 8'd30;

    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [3:0] max_setting;
        logic [9:0] tilt_confirm_ticks;
        logic [9:0] tilt_recover_ticks;
        logic [9:0] ticks_per_second;
        logic [7:0] fan_hold_seconds;
    } t_cfg;

    typedef struct packed {
        logic [3:0] time_setting;
        logic       key_beep;
        logic       alarm_beep;
        logic       standby_mode;
        logic       timer_running;
        logic       keys_locked;
        logic       relay_off;
        logic       fan_off;
        logic       timer_clear;
        logic       blink_restart;
        logic       short_delay_on;
        logic       tilt_confirmed;
    } t_result;

endpackage

FILE: hdl/key_and_tilt_supervisor_top.sv
// Top level of the key and tilt supervisor: stream ports, APB config, result register.
// Depends on ktsup_pkg, ktsup_cfg, ktsup_key, ktsup_ctrl and the macro header.
//
//  port group  dir  payload
//  s_axis      in   pass inputs: key, tilt, fast/slow ticks, quiet, timer start
//  m_axis      out  one result item per input item
//  apb         in   six config registers at byte addresses 0x00..0x14
//
// One item per cycle unless m_axis stalls; m_axis_tvalid rises the cycle after accept.
// All work sits between the supervisor state registers and the result register.
// Synchronous active-low reset clears state and loads register defaults.
// s_axis_tready stays high while the result register is empty or being taken.
`include "key_and_tilt_supervisor_top_macros.svh"

module key_and_tilt_supervisor_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] key_pin [1] tilt_pin [2] tick_fast [3] tick_slow [4] set_quiet
    // [5] timer_start [7:6] zero
    input  logic [ktsup_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] time_setting [4] key_beep [5] alarm_beep [6] standby_mode
    // [7] timer_running [8] keys_locked [9] relay_off [10] fan_off
    // [11] timer_clear [12] blink_restart [13] short_delay_on
    // [14] tilt_confirmed [15] zero
    output logic [ktsup_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ktsup_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    ktsup_pkg::t_cfg    w_cfg;
    ktsup_pkg::t_result w_res;
    ktsup_pkg::t_result r_res;
    logic               r_out_valid;
    logic               w_fire;
    logic               w_accepted;

    assign pready        = 1'b1;
    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign w_fire        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    ktsup_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    ktsup_key u_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_key_pin   (s_axis_tdata[0]),
        .i_tick_fast (s_axis_tdata[2]),
        .i_cfg       (w_cfg),
        .o_accepted  (w_accepted)
    );

    ktsup_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_accepted    (w_accepted),
        .i_tilt_pin    (s_axis_tdata[1]),
        .i_tick_slow   (s_axis_tdata[3]),
        .i_set_quiet   (s_axis_tdata[4]),
        .i_timer_start (s_axis_tdata[5]),
        .i_cfg         (w_cfg),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tdata = {1'b0,
                           r_res.tilt_confirmed,
                           r_res.short_delay_on,
                           r_res.blink_restart,
                           r_res.timer_clear,
                           r_res.fan_off,
                           r_res.relay_off,
                           r_res.keys_locked,
                           r_res.timer_running,
                           r_res.standby_mode,
                           r_res.alarm_beep,
                           r_res.key_beep,
                           r_res.time_setting};

    `KTS_ASSERT_NEXT(a_fire_gives_result, w_fire, r_out_valid)
    `KTS_ASSERT_NEXT(a_stall_keeps_result, r_out_valid && !m_axis_tready, r_out_valid)
    `KTS_ASSERT_NEXT(a_drain_without_fire, r_out_valid && m_axis_tready && !w_fire, !r_out_valid)

endmodule

FILE: hdl/ktsup_cfg.sv
// Configuration register file with an APB-style write/read port.
// Depends on ktsup_pkg.
module ktsup_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [ktsup_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]                      i_pwdata,
    output logic [31:0]                      o_prdata,
    output ktsup_pkg::t_cfg                  o_cfg
);

    ktsup_pkg::t_cfg  r_cfg;
    ktsup_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx = ktsup_pkg::t_reg_idx'(i_paddr[ktsup_pkg::CFG_ADDR_W-1:2]);
    assign w_wr  = i_psel & i_penable & i_pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= ktsup_pkg::RST_DEBOUNCE_TICKS;
            r_cfg.max_setting        <= ktsup_pkg::RST_MAX_SETTING;
            r_cfg.tilt_confirm_ticks <= ktsup_pkg::RST_TILT_CONFIRM_TICKS;
            r_cfg.tilt_recover_ticks <= ktsup_pkg::RST_TILT_RECOVER_TICKS;
            r_cfg.ticks_per_second   <= ktsup_pkg::RST_TICKS_PER_SECOND;
            r_cfg.fan_hold_seconds   <= ktsup_pkg::RST_FAN_HOLD_SECONDS;
        end else if (w_wr) begin
            case (w_idx)
                ktsup_pkg::REG_DEBOUNCE_TICKS:     r_cfg.debounce_ticks     <= i_pwdata[7:0];
                ktsup_pkg::REG_MAX_SETTING:        r_cfg.max_setting        <= i_pwdata[3:0];
                ktsup_pkg::REG_TILT_CONFIRM_TICKS: r_cfg.tilt_confirm_ticks <= i_pwdata[9:0];
                ktsup_pkg::REG_TILT_RECOVER_TICKS: r_cfg.tilt_recover_ticks <= i_pwdata[9:0];
                ktsup_pkg::REG_TICKS_PER_SECOND:   r_cfg.ticks_per_second   <= i_pwdata[9:0];
                ktsup_pkg::REG_FAN_HOLD_SECONDS:   r_cfg.fan_hold_seconds   <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ktsup_pkg::REG_DEBOUNCE_TICKS:     o_prdata = {24'd0, r_cfg.debounce_ticks};
            ktsup_pkg::REG_MAX_SETTING:        o_prdata = {28'd0, r_cfg.max_setting};
            ktsup_pkg::REG_TILT_CONFIRM_TICKS: o_prdata = {22'd0, r_cfg.tilt_confirm_ticks};
            ktsup_pkg::REG_TILT_RECOVER_TICKS: o_prdata = {22'd0, r_cfg.tilt_recover_ticks};
            ktsup_pkg::REG_TICKS_PER_SECOND:   o_prdata = {22'd0, r_cfg.ticks_per_second};
            ktsup_pkg::REG_FAN_HOLD_SECONDS:   o_prdata = {24'd0, r_cfg.fan_hold_seconds};
            default:                           o_prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/ktsup_key.sv
// Key debouncer: level tracking, countdown of latched fast ticks, press accept.
// Depends on ktsup_pkg and the assertion macro header.
`include "key_and_tilt_supervisor_top_macros.svh"

module ktsup_key (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_key_pin,
    input  logic            i_tick_fast,
    input  ktsup_pkg::t_cfg i_cfg,
    output logic            o_accepted
);

    logic       r_level, r_pending, r_latch;
    logic [7:0] r_left;
    logic       n_level, n_pending, n_latch;
    logic [7:0] n_left;

    always_comb begin
        n_level    = r_level;
        n_pending  = r_pending;
        n_left     = r_left;
        n_latch    = r_latch | i_tick_fast;
        o_accepted = 1'b0;
        if (i_key_pin) begin
            if (!r_level) begin
                n_level   = 1'b1;
                n_pending = 1'b0;
            end
        end else if (r_level) begin
            n_level   = 1'b0;
            n_pending = 1'b1;
            n_left    = i_cfg.debounce_ticks;
        end
        if (n_pending && n_left == 8'd0) begin
            n_pending  = 1'b0;
            o_accepted = 1'b1;
        end else if (n_pending && n_latch) begin
            n_latch = 1'b0;
            n_left  = n_left - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= 1'b0;
            r_pending <= 1'b0;
            r_latch   <= 1'b0;
            r_left    <= 8'd0;
        end else if (i_fire) begin
            r_level   <= n_level;
            r_pending <= n_pending;
            r_latch   <= n_latch;
            r_left    <= n_left;
        end
    end

    `KTS_ASSERT_NEXT(a_accept_clears_pending, i_fire && o_accepted, !r_pending)
    `KTS_ASSERT_NOW(a_accept_needs_low_key, o_accepted, !i_key_pin)
    `KTS_ASSERT_NEXT(a_release_cancels, i_fire && i_key_pin, !r_pending && r_level)

endmodule

FILE: hdl/ktsup_ctrl.sv
// Supervisor state: setting, tilt lockout, unlock, fan hold and result fields.
// Depends on ktsup_pkg and the assertion macro header.
`include "key_and_tilt_supervisor_top_macros.svh"

module ktsup_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_accepted,
    input  logic               i_tilt_pin,
    input  logic               i_tick_slow,
    input  logic               i_set_quiet,
    input  logic               i_timer_start,
    input  ktsup_pkg::t_cfg    i_cfg,
    output ktsup_pkg::t_result o_res
);

    logic [3:0] r_setting, n_setting;
    logic       r_locked, n_locked;
    logic       r_tilt_level, n_tilt_level;
    logic       r_entering, n_entering;
    logic       r_leaving, n_leaving;
    logic       r_done, n_done;
    logic [9:0] r_enter_cnt, n_enter_cnt;
    logic [9:0] r_leave_cnt, n_leave_cnt;
    logic [9:0] r_sec_cnt, n_sec_cnt;
    logic [7:0] r_hold_sec, n_hold_sec;
    logic       r_quiet, n_quiet;
    logic       r_running, n_running;
    logic       r_standby, n_standby;
    logic       r_half_delay, n_half_delay;
    logic       w_key_beep, w_alarm_beep, w_relay_off, w_fan_off;
    logic       w_timer_clear, w_blink;

    always_comb begin
        n_setting     = r_setting;
        n_locked      = r_locked;
        n_tilt_level  = r_tilt_level;
        n_entering    = r_entering;
        n_leaving     = r_leaving;
        n_done        = r_done;
        n_enter_cnt   = r_enter_cnt;
        n_leave_cnt   = r_leave_cnt;
        n_sec_cnt     = r_sec_cnt;
        n_hold_sec    = r_hold_sec;
        n_quiet       = r_quiet | i_set_quiet;
        n_running     = r_running | i_timer_start;
        n_standby     = r_standby;
        n_half_delay  = r_half_delay;
        w_key_beep    = 1'b0;
        w_alarm_beep  = 1'b0;
        w_relay_off   = 1'b0;
        w_fan_off     = 1'b0;
        w_timer_clear = 1'b0;
        w_blink       = 1'b0;

        if (i_accepted) begin
            if (!r_locked) begin
                w_blink       = 1'b1;
                n_setting     = (r_setting > 4'd1) ? r_setting - 4'd1 : i_cfg.max_setting;
                w_key_beep    = 1'b1;
                n_half_delay  = 1'b1;
                w_timer_clear = 1'b1;
                n_standby     = 1'b1;
                n_running     = 1'b0;
            end else begin
                w_alarm_beep = 1'b1;
            end
        end

        if (r_tilt_level != i_tilt_pin) begin
            n_tilt_level = i_tilt_pin;
            if (i_tilt_pin) begin
                n_quiet = 1'b0;
                if (r_entering) begin
                    n_entering = 1'b0;
                end else if (r_locked) begin
                    n_leaving   = 1'b1;
                    n_leave_cnt = 10'd0;
                end
            end else begin
                if (r_leaving) begin
                    n_leaving = 1'b0;
                end else if (!r_locked) begin
                    n_entering  = 1'b1;
                    n_enter_cnt = 10'd0;
                    n_hold_sec  = 8'd0;
                end
            end
        end

        if (i_tick_slow) begin
            if (n_entering) begin
                n_enter_cnt = n_enter_cnt + 10'd1;
                if (n_enter_cnt == i_cfg.tilt_confirm_ticks) begin
                    n_enter_cnt   = 10'd0;
                    n_entering    = 1'b0;
                    n_done        = 1'b1;
                    n_setting     = 4'd0;
                    n_running     = 1'b0;
                    n_locked      = 1'b1;
                    w_relay_off   = 1'b1;
                    w_timer_clear = 1'b1;
                    n_standby     = 1'b0;
                    w_blink       = 1'b1;
                    if (!n_quiet) begin
                        w_alarm_beep = 1'b1;
                    end
                end
            end
            if (n_leaving) begin
                n_leave_cnt = n_leave_cnt + 10'd1;
                if (n_leave_cnt == i_cfg.tilt_recover_ticks) begin
                    n_leave_cnt   = 10'd0;
                    n_leaving     = 1'b0;
                    n_locked      = 1'b0;
                    n_standby     = 1'b1;
                    n_half_delay  = 1'b0;
                    w_timer_clear = 1'b1;
                end
            end
            if (n_done) begin
                n_sec_cnt = n_sec_cnt + 10'd1;
                if (n_sec_cnt == i_cfg.ticks_per_second) begin
                    n_sec_cnt  = 10'd0;
                    n_hold_sec = n_hold_sec + 8'd1;
                    if (n_hold_sec == i_cfg.fan_hold_seconds) begin
                        n_hold_sec = 8'd0;
                        w_fan_off  = ~n_running;
                        n_done     = 1'b0;
                    end
                end
            end
        end

        // alarm restarts the buzzer last and wins over the key beep
        o_res.time_setting   = n_setting;
        o_res.key_beep       = w_key_beep & ~w_alarm_beep;
        o_res.alarm_beep     = w_alarm_beep;
        o_res.standby_mode   = n_standby;
        o_res.timer_running  = n_running;
        o_res.keys_locked    = n_locked;
        o_res.relay_off      = w_relay_off;
        o_res.fan_off        = w_fan_off;
        o_res.timer_clear    = w_timer_clear;
        o_res.blink_restart  = w_blink;
        o_res.short_delay_on = n_half_delay;
        o_res.tilt_confirmed = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting    <= 4'd0;
            r_locked     <= 1'b0;
            r_tilt_level <= 1'b0;
            r_entering   <= 1'b0;
            r_leaving    <= 1'b0;
            r_done       <= 1'b0;
            r_enter_cnt  <= 10'd0;
            r_leave_cnt  <= 10'd0;
            r_sec_cnt    <= 10'd0;
            r_hold_sec   <= 8'd0;
            r_quiet      <= 1'b0;
            r_running    <= 1'b0;
            r_standby    <= 1'b0;
            r_half_delay <= 1'b0;
        end else if (i_fire) begin
            r_setting    <= n_setting;
            r_locked     <= n_locked;
            r_tilt_level <= n_tilt_level;
            r_entering   <= n_entering;
            r_leaving    <= n_leaving;
            r_done       <= n_done;
            r_enter_cnt  <= n_enter_cnt;
            r_leave_cnt  <= n_leave_cnt;
            r_sec_cnt    <= n_sec_cnt;
            r_hold_sec   <= n_hold_sec;
            r_quiet      <= n_quiet;
            r_running    <= n_running;
            r_standby    <= n_standby;
            r_half_delay <= n_half_delay;
        end
    end

    `KTS_ASSERT_NOW(a_lock_drops_relay, !r_locked && n_locked, w_relay_off && w_timer_clear)
    `KTS_ASSERT_NOW(a_one_beep, 1'b1, !(o_res.key_beep && o_res.alarm_beep))
    `KTS_ASSERT_NOW(a_unlock_clears_timer, r_locked && !n_locked, w_timer_clear && n_standby)

endmodule

FILE: dv/ktsup_result_checker.sv
// Result checker for key_and_tilt_supervisor_top: watches s_axis, m_axis and APB,
// predicts each result item and compares it field by field. Depends on ktsup_pkg.
module ktsup_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [ktsup_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [ktsup_pkg::OUT_TDATA_W-1:0] i_out_data,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic                              i_pready,
    input  logic [ktsup_pkg::CFG_ADDR_W-1:0]  i_paddr,
    input  logic [31:0]                       i_pwdata,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    ktsup_pkg::t_cfg    cfg;
    ktsup_pkg::t_result predicted_results[$];

    logic       key_seen_high, press_armed, tick10_pending;
    logic [7:0] hold_left;
    logic [3:0] dur_setting;
    logic       lockout, tilt_up, tip_counting, upright_counting, fan_hold_active;
    logic [9:0] tip_ticks, upright_ticks, sec_ticks;
    logic [7:0] secs_held;
    logic       mute, run_flag, standby_on, half_sec_on;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic step_supervisor(input logic [5:0] pass, output ktsup_pkg::t_result r);
        logic kpin, tpin, tslow, accepted;
        kpin = pass[0];
        tpin = pass[1];
        tslow = pass[3];
        accepted = 1'b0;
        r = '0;

        if (pass[4]) mute = 1'b1;
        if (pass[5]) run_flag = 1'b1;
        if (pass[2]) tick10_pending = 1'b1;

        // debounce
        if (kpin) begin
            if (!key_seen_high) begin
                key_seen_high = 1'b1;
                press_armed = 1'b0;
            end
        end else if (key_seen_high) begin
            key_seen_high = 1'b0;
            press_armed = 1'b1;
            hold_left = cfg.debounce_ticks;
        end
        if (press_armed && hold_left == 8'd0) begin
            press_armed = 1'b0;
            accepted = 1'b1;
        end
        if (press_armed && hold_left != 8'd0 && tick10_pending) begin
            tick10_pending = 1'b0;
            hold_left = hold_left - 8'd1;
        end

        if (accepted) begin
            if (!lockout) begin
                r.blink_restart = 1'b1;
                dur_setting = (dur_setting > 4'd1) ? dur_setting - 4'd1 : cfg.max_setting;
                r.key_beep = 1'b1;
                half_sec_on = 1'b1;
                r.timer_clear = 1'b1;
                standby_on = 1'b1;
                run_flag = 1'b0;
            end else begin
                r.alarm_beep = 1'b1;
                r.key_beep = 1'b0;
            end
        end

        // tilt level change
        if (tilt_up != tpin) begin
            tilt_up = tpin;
            if (tpin) begin
                mute = 1'b0;
                if (tip_counting) begin
                    tip_counting = 1'b0;
                end else if (lockout) begin
                    upright_counting = 1'b1;
                    upright_ticks = '0;
                end
            end else begin
                if (upright_counting) begin
                    upright_counting = 1'b0;
                end else if (!lockout) begin
                    tip_counting = 1'b1;
                    tip_ticks = '0;
                    secs_held = '0;
                end
            end
        end

        if (tslow) begin
            if (tip_counting) begin
                tip_ticks = tip_ticks + 10'd1;
                if (tip_ticks == cfg.tilt_confirm_ticks) begin
                    tip_ticks = '0;
                    tip_counting = 1'b0;
                    fan_hold_active = 1'b1;
                    dur_setting = '0;
                    run_flag = 1'b0;
                    lockout = 1'b1;
                    r.relay_off = 1'b1;
                    r.timer_clear = 1'b1;
                    standby_on = 1'b0;
                    r.blink_restart = 1'b1;
                    if (!mute) begin
                        r.alarm_beep = 1'b1;
                        r.key_beep = 1'b0;
                    end
                end
            end
            if (upright_counting) begin
                upright_ticks = upright_ticks + 10'd1;
                if (upright_ticks == cfg.tilt_recover_ticks) begin
                    upright_ticks = '0;
                    upright_counting = 1'b0;
                    lockout = 1'b0;
                    standby_on = 1'b1;
                    half_sec_on = 1'b0;
                    r.timer_clear = 1'b1;
                end
            end
            if (fan_hold_active) begin
                sec_ticks = sec_ticks + 10'd1;
                if (sec_ticks == cfg.ticks_per_second) begin
                    sec_ticks = '0;
                    secs_held = secs_held + 8'd1;
                    if (secs_held == cfg.fan_hold_seconds) begin
                        secs_held = '0;
                        if (!run_flag) r.fan_off = 1'b1;
                        fan_hold_active = 1'b0;
                    end
                end
            end
        end

        r.time_setting = dur_setting;
        r.standby_mode = standby_on;
        r.timer_running = run_flag;
        r.keys_locked = lockout;
        r.short_delay_on = half_sec_on;
        r.tilt_confirmed = fan_hold_active;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        ktsup_pkg::t_result want, got;
        logic               in_acc, out_acc;
        in_acc = i_in_valid && i_in_ready;
        out_acc = i_out_valid && i_out_ready;
        if (!i_rst_n) begin
            cfg = '{ktsup_pkg::RST_DEBOUNCE_TICKS, ktsup_pkg::RST_MAX_SETTING,
                    ktsup_pkg::RST_TILT_CONFIRM_TICKS, ktsup_pkg::RST_TILT_RECOVER_TICKS,
                    ktsup_pkg::RST_TICKS_PER_SECOND, ktsup_pkg::RST_FAN_HOLD_SECONDS};
            {key_seen_high, press_armed, tick10_pending, lockout, tilt_up} = '0;
            {tip_counting, upright_counting, fan_hold_active} = '0;
            {mute, run_flag, standby_on, half_sec_on} = '0;
            hold_left = '0;
            dur_setting = '0;
            tip_ticks = '0;
            upright_ticks = '0;
            sec_ticks = '0;
            secs_held = '0;
            predicted_results.delete();
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (ktsup_pkg::t_reg_idx'(i_paddr[4:2]))
                    ktsup_pkg::REG_DEBOUNCE_TICKS:
                        cfg.debounce_ticks = i_pwdata[7:0];
                    ktsup_pkg::REG_MAX_SETTING:
                        cfg.max_setting = i_pwdata[3:0];
                    ktsup_pkg::REG_TILT_CONFIRM_TICKS:
                        cfg.tilt_confirm_ticks = i_pwdata[9:0];
                    ktsup_pkg::REG_TILT_RECOVER_TICKS:
                        cfg.tilt_recover_ticks = i_pwdata[9:0];
                    ktsup_pkg::REG_TICKS_PER_SECOND:
                        cfg.ticks_per_second = i_pwdata[9:0];
                    ktsup_pkg::REG_FAN_HOLD_SECONDS:
                        cfg.fan_hold_seconds = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                step_supervisor(i_in_data[5:0], want);
                predicted_results.push_back(want);
            end
            if (out_acc) begin
                got.time_setting = i_out_data[3:0];
                got.key_beep = i_out_data[4];
                got.alarm_beep = i_out_data[5];
                got.standby_mode = i_out_data[6];
                got.timer_running = i_out_data[7];
                got.keys_locked = i_out_data[8];
                got.relay_off = i_out_data[9];
                got.fan_off = i_out_data[10];
                got.timer_clear = i_out_data[11];
                got.blink_restart = i_out_data[12];
                got.short_delay_on = i_out_data[13];
                got.tilt_confirmed = i_out_data[14];
                if (predicted_results.size() == 0) begin
                    $error("result item with no prediction waiting: %h", i_out_data);
                    o_fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("time_setting", int'(want.time_setting),
                                int'(got.time_setting));
                    check_field("key_beep", int'(want.key_beep), int'(got.key_beep));
                    check_field("alarm_beep", int'(want.alarm_beep), int'(got.alarm_beep));
                    check_field("standby_mode", int'(want.standby_mode),
                                int'(got.standby_mode));
                    check_field("timer_running", int'(want.timer_running),
                                int'(got.timer_running));
                    check_field("keys_locked", int'(want.keys_locked),
                                int'(got.keys_locked));
                    check_field("relay_off", int'(want.relay_off), int'(got.relay_off));
                    check_field("fan_off", int'(want.fan_off), int'(got.fan_off));
                    check_field("timer_clear", int'(want.timer_clear),
                                int'(got.timer_clear));
                    check_field("blink_restart", int'(want.blink_restart),
                                int'(got.blink_restart));
                    check_field("short_delay_on", int'(want.short_delay_on),
                                int'(got.short_delay_on));
                    check_field("tilt_confirmed", int'(want.tilt_confirmed),
                                int'(got.tilt_confirmed));
                end
            end
            o_pending <= o_pending + int'(in_acc) - int'(out_acc);
        end
    end

endmodule

FILE: dv/tb_key_and_tilt_supervisor_top.sv
// Testbench top for key_and_tilt_supervisor_top: clock, reset, APB config phases,
// directed and random pass items, random back-pressure. Depends on ktsup_pkg
// and ktsup_result_checker.
module tb_key_and_tilt_supervisor_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [ktsup_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [ktsup_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              psel, penable, pwrite, pready;
    logic [ktsup_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [31:0]                       pwdata, prdata;

    int   fail_count, pending, cycles = 0;
    logic calm = 1'b0;
    logic key_up = 1'b1;
    logic upright = 1'b1;

    key_and_tilt_supervisor_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ktsup_result_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("key_and_tilt_supervisor_top verification failed");
            $finish;
        end
    end

    function automatic logic [5:0] make_pass(input logic key, tilt, fast, slow, mute, start);
        return {start, mute, slow, fast, tilt, key};
    endfunction

    function automatic ktsup_pkg::t_cfg make_cfg(input int deb, maxs, conf, recv, tps, hold);
        ktsup_pkg::t_cfg c;
        c.debounce_ticks = deb[7:0];
        c.max_setting = maxs[3:0];
        c.tilt_confirm_ticks = conf[9:0];
        c.tilt_recover_ticks = recv[9:0];
        c.ticks_per_second = tps[9:0];
        c.fan_hold_seconds = hold[7:0];
        return c;
    endfunction

    function automatic ktsup_pkg::t_cfg random_cfg();
        return make_cfg($urandom_range(0, 4), $urandom_range(0, 15), $urandom_range(1, 6),
                        $urandom_range(1, 6), $urandom_range(1, 3), $urandom_range(1, 3));
    endfunction

    task automatic write_reg(input ktsup_pkg::t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ktsup_pkg::CFG_ADDR_W'(int'(idx) * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic load_cfg(input ktsup_pkg::t_cfg c);
        write_reg(ktsup_pkg::REG_DEBOUNCE_TICKS, 32'(c.debounce_ticks));
        write_reg(ktsup_pkg::REG_MAX_SETTING, 32'(c.max_setting));
        write_reg(ktsup_pkg::REG_TILT_CONFIRM_TICKS, 32'(c.tilt_confirm_ticks));
        write_reg(ktsup_pkg::REG_TILT_RECOVER_TICKS, 32'(c.tilt_recover_ticks));
        write_reg(ktsup_pkg::REG_TICKS_PER_SECOND, 32'(c.ticks_per_second));
        write_reg(ktsup_pkg::REG_FAN_HOLD_SECONDS, 32'(c.fan_hold_seconds));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pass(input logic [5:0] pass);
        while (!calm && $urandom_range(0, 99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, pass};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // every pass yields a result, so an empty scoreboard means the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count, input bit noisy);
        int key_flip, tilt_flip;
        key_flip = noisy ? 40 : 8;
        tilt_flip = noisy ? 30 : 2;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < key_flip) key_up = !key_up;
            if ($urandom_range(0, 99) < tilt_flip) upright = !upright;
            send_pass(make_pass(key_up, upright, 1'($urandom_range(0, 1)),
                                $urandom_range(0, 99) < 60, $urandom_range(0, 99) < 4,
                                $urandom_range(0, 99) < 6));
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults; upright pin on the first pass is an upright edge
        send_pass(make_pass(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        send_pass(make_pass(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_pass(6'h3f);
        drain();

        // zero debounce, zero max_setting, short tilt windows
        load_cfg(make_cfg(0, 0, 2, 2, 1, 2));
        send_pass(make_pass(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_pass(make_pass(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));  // press and tilt lockout together, alarm muted
        send_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));  // fan hold already ended, timer idle
        send_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));  // press while locked
        send_pass(make_pass(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        send_pass(make_pass(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));  // unlock
        send_pass(make_pass(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        send_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));  // quiet lockout
        send_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));  // fan hold already ended, timer running
        send_pass(make_pass(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_pass(6'h3f);
        drain();

        calm = 1'b1;
        load_cfg(random_cfg());
        random_phase(90, 0);
        drain();
        calm = 1'b0;

        load_cfg(make_cfg(255, 15, 1023, 1023, 1023, 255));
        random_phase(70, 0);
        drain();

        load_cfg(make_cfg(1, 1, 1, 1, 1, 1));
        random_phase(80, 0);
        drain();

        load_cfg(make_cfg(0, 0, 0, 0, 0, 0));
        random_phase(60, 1);
        drain();

        load_cfg(random_cfg());
        random_phase(90, 1);
        drain();

        load_cfg(random_cfg());
        random_phase(110, 0);
        drain();

        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("key_and_tilt_supervisor_top verification clean");
        end else begin
            $display("key_and_tilt_supervisor_top verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/ktsup_pkg.sv
hdl/ktsup_cfg.sv
hdl/ktsup_key.sv
hdl/ktsup_ctrl.sv
hdl/key_and_tilt_supervisor_top.sv
dv/ktsup_result_checker.sv
dv/tb_key_and_tilt_supervisor_top.sv
